// ===== hw/rtl/mvhsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mvhsp_pkg
// Types, constants and the control store for the VOL header size parser.
// ----------------------------------------------------------------------------
package mvhsp_pkg;

    localparam int DIM_BITS  = 13;
    localparam int RES_BITS  = 16;
    localparam int LEN_BITS  = 5;
    localparam int DATA_BITS = 8;
    localparam int OUT_BITS  = ((2 * DIM_BITS + 7) / 8) * 8;

    localparam logic [3:0] AR_EXTENDED_PAR = 4'd15;
    localparam logic [1:0] SHAPE_RECT      = 2'd0;
    localparam logic [1:0] SHAPE_GRAY      = 2'd3;
    localparam logic [3:0] VERID_ONE       = 4'd1;

    typedef enum logic [4:0] {
        PH_RANDOM    = 5'd0,
        PH_TYPE      = 5'd1,
        PH_HAS_ID    = 5'd2,
        PH_VER_PRIO  = 5'd3,
        PH_ASPECT    = 5'd4,
        PH_PAR       = 5'd5,
        PH_CTRL      = 5'd6,
        PH_CHROMA_LD = 5'd7,
        PH_VBV_FLAG  = 5'd8,
        PH_VBV1      = 5'd9,
        PH_VBV2      = 5'd10,
        PH_VBV3      = 5'd11,
        PH_VBV4      = 5'd12,
        PH_VBV5      = 5'd13,
        PH_SHAPE     = 5'd14,
        PH_SHAPE_EXT = 5'd15,
        PH_RES       = 5'd16,
        PH_FIXED     = 5'd17,
        PH_FIXED_INC = 5'd18,
        PH_WIDTH     = 5'd19,
        PH_HEIGHT    = 5'd20
    } t_phase;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_BIT0,
        COND_ASPECT,
        COND_GRAY
    } t_cond;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_HAS_ID,
        ACT_VER,
        ACT_SHAPE,
        ACT_RES,
        ACT_FIXED,
        ACT_RATE,
        ACT_WIDTH,
        ACT_HEIGHT
    } t_act;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHAPE = 2'd1,
        ST_TRUNC = 2'd2
    } t_status;

    typedef struct packed {
        logic [LEN_BITS-1:0] len;
        logic                len_inc;
        t_cond               cond;
        t_act                act;
        t_phase              next;
        t_phase              alt;
    } t_uword;

    function automatic t_uword uw(input logic [LEN_BITS-1:0] len, input logic len_inc,
                                  input t_cond cond, input t_act act,
                                  input t_phase next, input t_phase alt);
        t_uword w;
        w.len     = len;
        w.len_inc = len_inc;
        w.cond    = cond;
        w.act     = act;
        w.next    = next;
        w.alt     = alt;
        return w;
    endfunction

    function automatic t_uword ucode_rom(input t_phase ph);
        t_uword w;
        case (ph)
            PH_RANDOM:    w = uw(5'd1,  1'b0, COND_NONE,   ACT_NONE,   PH_TYPE,     PH_TYPE);
            PH_TYPE:      w = uw(5'd8,  1'b0, COND_NONE,   ACT_NONE,   PH_HAS_ID,   PH_HAS_ID);
            PH_HAS_ID:    w = uw(5'd1,  1'b0, COND_BIT0,   ACT_HAS_ID, PH_ASPECT,   PH_VER_PRIO);
            PH_VER_PRIO:  w = uw(5'd7,  1'b0, COND_NONE,   ACT_VER,    PH_ASPECT,   PH_ASPECT);
            PH_ASPECT:    w = uw(5'd4,  1'b0, COND_ASPECT, ACT_NONE,   PH_CTRL,     PH_PAR);
            PH_PAR:       w = uw(5'd16, 1'b0, COND_NONE,   ACT_NONE,   PH_CTRL,     PH_CTRL);
            PH_CTRL:      w = uw(5'd1,  1'b0, COND_BIT0,   ACT_NONE,   PH_SHAPE,    PH_CHROMA_LD);
            PH_CHROMA_LD: w = uw(5'd3,  1'b0, COND_NONE,   ACT_NONE,   PH_VBV_FLAG, PH_VBV_FLAG);
            PH_VBV_FLAG:  w = uw(5'd1,  1'b0, COND_BIT0,   ACT_NONE,   PH_SHAPE,    PH_VBV1);
            PH_VBV1:      w = uw(5'd16, 1'b0, COND_NONE,   ACT_NONE,   PH_VBV2,     PH_VBV2);
            PH_VBV2:      w = uw(5'd16, 1'b0, COND_NONE,   ACT_NONE,   PH_VBV3,     PH_VBV3);
            PH_VBV3:      w = uw(5'd16, 1'b0, COND_NONE,   ACT_NONE,   PH_VBV4,     PH_VBV4);
            PH_VBV4:      w = uw(5'd15, 1'b0, COND_NONE,   ACT_NONE,   PH_VBV5,     PH_VBV5);
            PH_VBV5:      w = uw(5'd16, 1'b0, COND_NONE,   ACT_NONE,   PH_SHAPE,    PH_SHAPE);
            PH_SHAPE:     w = uw(5'd2,  1'b0, COND_GRAY,   ACT_SHAPE,  PH_RES,      PH_SHAPE_EXT);
            PH_SHAPE_EXT: w = uw(5'd4,  1'b0, COND_NONE,   ACT_NONE,   PH_RES,      PH_RES);
            PH_RES:       w = uw(5'd17, 1'b0, COND_NONE,   ACT_RES,    PH_FIXED,    PH_FIXED);
            PH_FIXED:     w = uw(5'd2,  1'b0, COND_NONE,   ACT_FIXED,  PH_WIDTH,    PH_FIXED_INC);
            PH_FIXED_INC: w = uw(5'd0,  1'b1, COND_NONE,   ACT_RATE,   PH_WIDTH,    PH_WIDTH);
            PH_WIDTH:     w = uw(5'd14, 1'b0, COND_NONE,   ACT_WIDTH,  PH_HEIGHT,   PH_HEIGHT);
            PH_HEIGHT:    w = uw(5'd14, 1'b0, COND_NONE,   ACT_HEIGHT, PH_RANDOM,   PH_RANDOM);
            default:      w = uw(5'd1,  1'b0, COND_NONE,   ACT_NONE,   PH_RANDOM,   PH_RANDOM);
        endcase
        return w;
    endfunction

    // bit length of (res - 1), never below one
    function automatic logic [LEN_BITS-1:0] inc_bits(input logic [RES_BITS-1:0] res);
        logic [RES_BITS-1:0] v;
        logic [LEN_BITS-1:0] n;
        v = res - RES_BITS'(1);
        n = '0;
        for (int i = 0; i < RES_BITS; i++) begin
            if (v[i]) begin
                n = LEN_BITS'(i + 1);
            end
        end
        if (res == '0 || n == '0) begin
            n = LEN_BITS'(1);
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/mpeg4_vol_header_size_parser_core.sv =====
// ----------------------------------------------------------------------------
// mpeg4_vol_header_size_parser_core
// Bit-serial VOL header walker that reports the layer width and height.
// ----------------------------------------------------------------------------
// Header bytes (after the start code) enter on the slave stream, tuser set on
// the first byte of a header and tlast on the final available byte. Each byte
// is consumed one bit per cycle, when the output is free, by a microcoded field
// walker, so a byte holds the input while it is accepted and its eight bits
// are shifted; it frees the input sooner when a result ends the header inside
// the byte, and a byte that comes after the header has finished is dropped in
// its acceptance cycle. The walker stalls while a result waits in the output register. The master
// stream carries at most one transaction per header: width and height with
// status ok, status shape for non-rectangular layers, or status truncated
// when tlast arrives before the dimensions are complete.
module mpeg4_vol_header_size_parser_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [mvhsp_pkg::DATA_BITS-1:0] i_s_tdata,  // [7:0] data_byte
    input  logic                           i_s_tuser,  // header_start
    input  logic                           i_s_tlast,  // last_byte
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [mvhsp_pkg::OUT_BITS-1:0] o_m_tdata,  // [12:0] frame_width,
                                                       // [25:13] frame_height, zero pad
    output logic [1:0]                     o_m_tuser   // [1:0] parse_status
);
    import mvhsp_pkg::*;

    t_phase                r_phase,    n_phase;
    logic [LEN_BITS-1:0]   r_left,     n_left;
    logic [RES_BITS-1:0]   r_acc,      n_acc;
    logic                  r_ver_one,  n_ver_one;
    logic [1:0]            r_shape,    n_shape;
    logic [LEN_BITS-1:0]   r_inc_cnt,  n_inc_cnt;
    logic [DIM_BITS-1:0]   r_width,    n_width;
    logic                  r_finished, n_finished;
    logic                  r_busy,     n_busy;
    logic [DATA_BITS-1:0]  r_byte,     n_byte;
    logic                  r_last,     n_last;
    logic [2:0]            r_bit_idx,  n_bit_idx;
    logic                  r_out_valid, n_out_valid;
    logic [DIM_BITS-1:0]   r_out_w,    n_out_w;
    logic [DIM_BITS-1:0]   r_out_h,    n_out_h;
    t_status               r_out_st,   n_out_st;

    t_uword                ucw;
    logic                  accept;
    logic                  out_free;
    logic                  step_en;
    logic                  bit_in;
    logic                  fld_start;
    logic [LEN_BITS-1:0]   len_eff;
    logic [LEN_BITS-1:0]   cur_left;
    logic [LEN_BITS-1:0]   new_left;
    logic [RES_BITS-1:0]   new_acc;
    logic                  take_alt;
    logic                  emit;
    logic                  out_load;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign step_en  = r_busy && out_free;
    assign ucw      = ucode_rom(r_phase);
    assign bit_in   = r_byte[r_bit_idx];
    assign fld_start = (r_left == '0);

    always_comb begin
        len_eff = ucw.len_inc ? r_inc_cnt : ucw.len;
        if (len_eff == '0) begin
            len_eff = LEN_BITS'(1);
        end
    end

    assign cur_left = fld_start ? len_eff : r_left;
    assign new_left = cur_left - LEN_BITS'(1);
    assign new_acc  = {(fld_start ? {(RES_BITS-1){1'b0}} : r_acc[RES_BITS-2:0]), bit_in};

    always_comb begin
        case (ucw.cond)
            COND_BIT0:   take_alt = new_acc[0];
            COND_ASPECT: take_alt = (new_acc[3:0] == AR_EXTENDED_PAR);
            COND_GRAY:   take_alt = (new_acc[1:0] == SHAPE_GRAY) && !r_ver_one;
            default:     take_alt = 1'b0;
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_left      = r_left;
        n_acc       = r_acc;
        n_ver_one   = r_ver_one;
        n_shape     = r_shape;
        n_inc_cnt   = r_inc_cnt;
        n_width     = r_width;
        n_finished  = r_finished;
        n_busy      = r_busy;
        n_byte      = r_byte;
        n_last      = r_last;
        n_bit_idx   = r_bit_idx;
        n_out_w     = r_out_w;
        n_out_h     = r_out_h;
        n_out_st    = r_out_st;
        emit        = 1'b0;
        out_load    = 1'b0;

        if (accept) begin
            n_byte    = i_s_tdata;
            n_last    = i_s_tlast;
            n_bit_idx = 3'd7;
            if (i_s_tuser) begin
                n_phase    = PH_RANDOM;
                n_left     = '0;
                n_ver_one  = 1'b1;
                n_shape    = SHAPE_RECT;
                n_inc_cnt  = LEN_BITS'(1);
                n_finished = 1'b0;
                n_busy     = 1'b1;
            end else begin
                n_busy     = !r_finished;
            end
        end else if (step_en) begin
            n_acc     = new_acc;
            n_left    = new_left;
            n_bit_idx = r_bit_idx - 3'd1;
            if (new_left == '0) begin
                n_phase = take_alt ? ucw.alt : ucw.next;
                case (ucw.act)
                    ACT_HAS_ID: begin
                        if (!new_acc[0]) begin
                            n_ver_one = 1'b1;
                        end
                    end
                    ACT_VER:    n_ver_one = (new_acc[6:3] == VERID_ONE);
                    ACT_SHAPE:  n_shape   = new_acc[1:0];
                    ACT_RES:    n_inc_cnt = inc_bits(new_acc);
                    ACT_FIXED, ACT_RATE: begin
                        if (ucw.act == ACT_FIXED && new_acc[0]) begin
                            n_phase = ucw.alt;
                        end else if (r_shape == SHAPE_RECT) begin
                            n_phase = PH_WIDTH;
                        end else begin
                            emit     = 1'b1;
                            n_out_w  = '0;
                            n_out_h  = '0;
                            n_out_st = ST_SHAPE;
                        end
                    end
                    ACT_WIDTH:  n_width = new_acc[DIM_BITS-1:0];
                    ACT_HEIGHT: begin
                        emit     = 1'b1;
                        n_out_w  = r_width;
                        n_out_h  = new_acc[DIM_BITS-1:0];
                        n_out_st = ST_OK;
                    end
                    default: ;
                endcase
            end
            if (emit) begin
                n_finished = 1'b1;
                n_busy     = 1'b0;
                out_load   = 1'b1;
            end else if (r_bit_idx == 3'd0) begin
                n_busy = 1'b0;
                if (r_last) begin
                    n_finished = 1'b1;
                    out_load   = 1'b1;
                    n_out_w    = '0;
                    n_out_h    = '0;
                    n_out_st   = ST_TRUNC;
                end
            end
        end

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RANDOM;
            r_left      <= '0;
            r_ver_one   <= 1'b1;
            r_shape     <= SHAPE_RECT;
            r_inc_cnt   <= LEN_BITS'(1);
            r_finished  <= 1'b0;
            r_busy      <= 1'b0;
            r_bit_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_left      <= n_left;
            r_ver_one   <= n_ver_one;
            r_shape     <= n_shape;
            r_inc_cnt   <= n_inc_cnt;
            r_finished  <= n_finished;
            r_busy      <= n_busy;
            r_bit_idx   <= n_bit_idx;
            r_out_valid <= n_out_valid;
        end
        r_acc    <= n_acc;
        r_width  <= n_width;
        r_byte   <= n_byte;
        r_last   <= n_last;
        r_out_w  <= n_out_w;
        r_out_h  <= n_out_h;
        r_out_st <= n_out_st;
    end

    assign o_s_tready = !r_busy;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_BITS - 2 * DIM_BITS){1'b0}}, r_out_h, r_out_w};
    assign o_m_tuser  = r_out_st;

    a_emit_ends_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (!r_busy && r_finished && r_out_valid))
        else $error("result did not end byte processing");

    a_byte_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_en && r_bit_idx == 3'd0) |=> !r_busy)
        else $error("byte processing ran past eight bits");

    a_inc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inc_cnt != '0) && (r_inc_cnt <= LEN_BITS'(RES_BITS)))
        else $error("increment bit count out of range");

    a_no_step_when_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_finished)
        else $error("walker active after header finished");

endmodule
